// ===== rtl/core/dts_pkg.sv =====
package dts_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned MilliW  = 10;
  localparam int unsigned SerialW = 22;
  localparam int unsigned MillisW = 27;
  localparam int unsigned CentW   = 8;
  localparam int unsigned DbmW    = 9;

  localparam logic [YearW-1:0]   EpochYear = 14'd1900;
  localparam logic [YearW-1:0]   LastYear  = 14'd9999;
  localparam logic [MillisW-1:0] MsPerDay  = 27'd86400000;
  localparam logic [MillisW-1:0] MsPerHour = 27'd3600000;
  localparam logic [MillisW-1:0] MsPerMin  = 27'd60000;
  localparam logic [MillisW-1:0] MsPerSec  = 27'd1000;

  // Multiplying a year by Div100Mul and dropping Div100Shift bits gives the year
  // divided by 100, exact for every 14-bit value.
  localparam int unsigned        Div100Shift = 19;
  localparam logic [26:0]        Div100Mul   = 27'd5243;
  localparam logic [14:0]        Hundred     = 15'd100;
  localparam logic [SerialW-1:0] DaysPerYear = 22'd365;

  // Leap years of 1..1899 is 460; one is added back for the 1900 quirk.
  localparam logic [YearW-1:0] LeapBias = 14'd459;

  typedef struct packed {
    logic                 range_ok;
    logic [YearW-1:0]     year;
    logic [YearW-1:0]     year_m1;
    logic [MonthW-1:0]    month;
    logic [DayW-1:0]      day;
    logic [SerialW-1:0]   year_days;
    logic [CentW-1:0]     cent_y;
    logic [CentW-1:0]     cent_m1;
    logic [MillisW-1:0]   ms_hour;
    logic [MillisW-1:0]   ms_min;
    logic [MillisW-1:0]   ms_sec;
    logic [MilliW-1:0]    milli;
  } s1_t;

  typedef struct packed {
    logic               date_ok;
    logic [SerialW-1:0] serial;
    logic [MillisW-1:0] ms;
  } s2_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DbmW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DbmW-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/dts_decode.sv =====
module dts_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take,
  input  logic [dts_pkg::YearW-1:0]        year,
  input  logic [dts_pkg::MonthW-1:0]       month,
  input  logic [dts_pkg::DayW-1:0]         day,
  input  logic [dts_pkg::HourW-1:0]        hour,
  input  logic [dts_pkg::MinuteW-1:0]      minute,
  input  logic [dts_pkg::SecondW-1:0]      second,
  input  logic [dts_pkg::MilliW-1:0]       millisecond,
  output logic                             s1_valid,
  output dts_pkg::s1_t                     s1
);
  import dts_pkg::*;

  logic  s1_valid_r;
  s1_t   s1_r;
  s1_t   s1_nxt;
  logic [YearW-1:0] year_m1;
  logic [26:0]      prod_y;
  logic [26:0]      prod_m1;

  always_comb begin
    year_m1 = year - 14'd1;
    prod_y  = 27'(year) * Div100Mul;
    prod_m1 = 27'(year_m1) * Div100Mul;

    s1_nxt.range_ok  = (year >= EpochYear) && (year <= LastYear) &&
                       (month >= 4'd1) && (month <= 4'd12);
    s1_nxt.year      = year;
    s1_nxt.year_m1   = year_m1;
    s1_nxt.month     = month;
    s1_nxt.day       = day;
    s1_nxt.year_days = SerialW'(year - EpochYear) * DaysPerYear;
    s1_nxt.cent_y    = prod_y[Div100Shift +: CentW];
    s1_nxt.cent_m1   = prod_m1[Div100Shift +: CentW];
    s1_nxt.ms_hour   = MillisW'(hour) * MsPerHour;
    s1_nxt.ms_min    = MillisW'(minute) * MsPerMin;
    s1_nxt.ms_sec    = MillisW'(second) * MsPerSec;
    s1_nxt.milli     = millisecond;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

// ===== rtl/core/dts_count.sv =====
module dts_count (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  dts_pkg::s1_t  s1,
  output logic          s2_valid,
  output dts_pkg::s2_t  s2
);
  import dts_pkg::*;

  logic  s2_valid_r;
  s2_t   s2_r;
  s2_t   s2_nxt;
  logic  is_cent;
  logic  leap;
  logic  day_ok;
  logic [YearW-1:0]   leap_days;
  logic [DayW-1:0]    mlen;

  always_comb begin
    is_cent = ((15'(s1.cent_y) * Hundred) == 15'(s1.year));
    leap    = (s1.year == EpochYear) ||
              ((s1.year[1:0] == 2'd0) && (!is_cent || (s1.cent_y[1:0] == 2'd0)));
    mlen    = month_len(s1.month, leap);
    day_ok  = (s1.day != 5'd0) && (s1.day <= mlen);

    if (s1.year > EpochYear) begin
      leap_days = YearW'(s1.year_m1[YearW-1:2]) - YearW'(s1.cent_m1) +
                  YearW'(s1.cent_m1[CentW-1:2]) - LeapBias;
    end else begin
      leap_days = '0;
    end

    s2_nxt.date_ok = s1.range_ok && day_ok;
    s2_nxt.serial  = s1.year_days + SerialW'(leap_days) +
                     SerialW'(days_before(s1.month)) +
                     SerialW'((s1.month > 4'd2) && leap) + SerialW'(s1.day);
    s2_nxt.ms      = s1.ms_hour + s1.ms_min + s1.ms_sec + MillisW'(s1.milli);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

// ===== rtl/core/dts_finish.sv =====
module dts_finish (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s2_valid,
  input  dts_pkg::s2_t                  s2,
  output logic                          out_strobe,
  output logic [dts_pkg::SerialW-1:0]   out_serial_day,
  output logic [dts_pkg::MillisW-1:0]   out_day_millis,
  output logic                          out_valid_res
);
  import dts_pkg::*;

  logic               strobe_r;
  logic [SerialW-1:0] serial_r;
  logic [SerialW-1:0] serial_nxt;
  logic [MillisW-1:0] millis_r;
  logic [MillisW-1:0] millis_nxt;
  logic               ok_r;
  logic               carry;

  always_comb begin
    carry = (s2.ms >= MsPerDay);
    if (!s2.date_ok) begin
      serial_nxt = '0;
      millis_nxt = '0;
    end else if (carry) begin
      serial_nxt = s2.serial + 22'd1;
      millis_nxt = s2.ms - MsPerDay;
    end else begin
      serial_nxt = s2.serial;
      millis_nxt = s2.ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      serial_r <= serial_nxt;
      millis_r <= millis_nxt;
      ok_r     <= s2.date_ok;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_serial_day = serial_r;
  assign out_day_millis = millis_r;
  assign out_valid_res  = ok_r;

endmodule

// ===== rtl/core/datetime_to_day_serial_unit.sv =====
// Converts a calendar date and time of day into the 1900-system spreadsheet
// serial day, with 1900-01-01 as day 1 and 1900 counted as a leap year, and
// gives the time of day in milliseconds beside it. The unit is a three-stage
// pipeline: an item can be started in every clock cycle once reset has
// released busy. Each result passes the decode, count and finish registers
// in that order to reach the out_ ports, where out_strobe marks it by going
// high for a single cycle. Results leave in the order their items
// entered and cannot be held off, so the receiver must take each one in the
// cycle it is shown. A bad year, month or day gives out_valid_res low with
// zero serial day and milliseconds; time fields beyond a day carry one day
// into the serial.
module datetime_to_day_serial_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [dts_pkg::YearW-1:0]       in_year,
  input  logic [dts_pkg::MonthW-1:0]      in_month,
  input  logic [dts_pkg::DayW-1:0]        in_day,
  input  logic [dts_pkg::HourW-1:0]       in_hour,
  input  logic [dts_pkg::MinuteW-1:0]     in_minute,
  input  logic [dts_pkg::SecondW-1:0]     in_second,
  input  logic [dts_pkg::MilliW-1:0]      in_millisecond,
  output logic                            out_strobe,
  output logic [dts_pkg::SerialW-1:0]     out_serial_day,
  output logic [dts_pkg::MillisW-1:0]     out_day_millis,
  output logic                            out_valid_res
);
  import dts_pkg::*;

  logic busy_r;
  logic take;
  logic s1_valid;
  s1_t  s1;
  logic s2_valid;
  s2_t  s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign take = start && !busy_r;

  dts_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .year        (in_year),
    .month       (in_month),
    .day         (in_day),
    .hour        (in_hour),
    .minute      (in_minute),
    .second      (in_second),
    .millisecond (in_millisecond),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  dts_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  dts_finish u_finish (
    .clk            (clk),
    .rst_n          (rst_n),
    .s2_valid       (s2_valid),
    .s2             (s2),
    .out_strobe     (out_strobe),
    .out_serial_day (out_serial_day),
    .out_day_millis (out_day_millis),
    .out_valid_res  (out_valid_res)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##3 out_strobe)
    else $error("item taken without a result three cycles later");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(s1_valid, 2))
    else $error("result shown without an item behind it");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_serial_day == '0 && out_day_millis == '0))
    else $error("invalid result carries non-zero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res) |-> (out_day_millis < MsPerDay && out_serial_day != '0))
    else $error("valid result out of range");

endmodule
